// ===== hw/rtl/ray_box_slab_intersect_2d_defines.svh =====
// Assertion macros for the ray and box intersection checker.
`ifndef RAY_BOX_SLAB_INTERSECT_2D_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_2D_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RBSI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbsi check failed");

// Next-cycle implication, disabled while reset is high.
`define RBSI_ASSERT_NXT(lbl, clk, ante, cons, rst) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbsi check failed");

// Next-cycle implication that also holds across reset.
`define RBSI_ASSERT_NXT_ANY(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rbsi check failed");

`endif

// ===== hw/rtl/rbsi_pkg.sv =====
// Types and constants shared by the ray and box intersection pipeline.
package rbsi_pkg;

   localparam int DataW   = 32;
   localparam int ThrW    = 16;
   localparam int CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MAX_X = 3'd2,
      CSR_BOX_MAX_Y = 3'd3,
      CSR_THRESHOLD = 3'd4
   } csr_index_type;

   // Per-ray data that rides alongside the dividers.
   typedef struct packed {
      logic signed [DataW-1:0] org_x;
      logic signed [DataW-1:0] org_y;
      logic signed [DataW-1:0] dir_x;
      logic signed [DataW-1:0] dir_y;
      logic                    par_x;
      logic                    par_y;
      logic                    prej_x;
      logic                    prej_y;
      logic [3:0]              qneg;
   } side_type;

endpackage

// ===== hw/rtl/rbsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rbsi_div #(
   parameter int QW = 48
) (
   input  logic          clock,
   input  logic          en,
   input  logic [QW-1:0] num_in,
   input  logic [31:0]   den_in,
   output logic [QW-1:0] quo
);
   import rbsi_pkg::*;

   // Each stage shifts the numerator out at the top and the quotient in at the bottom.
   logic [QW-1:0] nq_ff  [QW];
   logic [31:0]   rem_ff [QW];
   logic [31:0]   den_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [QW-1:0] nq_prev;
      logic [31:0]   rem_prev;
      logic [31:0]   den_prev;
      logic [32:0]   trial;
      logic [32:0]   diff;
      logic          ge;
      logic [QW-1:0] nq_in;
      logic [31:0]   rem_in;

      if (s == 0) begin : g_first
         assign nq_prev  = num_in;
         assign rem_prev = '0;
         assign den_prev = den_in;
      end else begin : g_next
         assign nq_prev  = nq_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
      end

      always_comb begin
         trial  = {rem_prev, nq_prev[QW-1]};
         diff   = trial - {1'b0, den_prev};
         ge     = (trial >= {1'b0, den_prev});
         rem_in = ge ? diff[31:0] : trial[31:0];
         nq_in  = {nq_prev[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[s]  <= nq_in;
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_prev;
         end
      end
   end

   assign quo = nq_ff[QW-1];

endmodule

// ===== hw/rtl/ray_box_slab_intersect_2d.sv =====
// Slab test of a 2D ray against a configured box, giving a hit flag and the hit point.
// One ray is taken every cycle unless the pipeline stalls. A request passes through:
// one input stage, 32 + FRAC_BITS stages of the four parallel restoring dividers that
// produce the slab parameters (one quotient bit per stage), a stage that orders the two
// parameters of each axis, a stage that merges the slab intervals, a multiplier stage,
// a clamp stage and the saturating output register.
// When the result side stalls a waiting result, the whole pipeline holds and req_stall
// rises in the same cycle. The box corners and parallel threshold are to be written by
// the user through the csr port while no request is in flight; it is not enforced.
module ray_box_slab_intersect_2d #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_origin_x,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_origin_y,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_direction_x,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_direction_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic signed [rbsi_pkg::DataW-1:0]  rsp_hit_x,
   output logic signed [rbsi_pkg::DataW-1:0]  rsp_hit_y,
   input  logic                               csr_we,
   input  logic [rbsi_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [rbsi_pkg::DataW-1:0]         csr_wdata
);
   import rbsi_pkg::*;

   localparam int QW  = 32 + FRAC_BITS;
   localparam int TW  = QW + 2;
   localparam int HiW = QW - 32;
   localparam int PHW = 32 + HiW;
   localparam logic signed [TW-1:0] TMin = {1'b1, {(TW-1){1'b0}}};
   localparam logic signed [TW-1:0] TMax = {1'b0, {(TW-1){1'b1}}};
   localparam logic [PHW-1:0] HiLimit = {{(PHW-1){1'b0}}, 1'b1} << (FRAC_BITS + 2);
   localparam logic [65:0]    CapWide = {{65{1'b0}}, 1'b1} << 34;
   localparam logic [34:0]    Cap     = {1'b1, 34'd0};

   function automatic logic [31:0] mag33(input logic [32:0] v);
      logic [32:0] a;
      a = v[32] ? (~v + 33'd1) : v;
      return a[31:0];
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // Magnitude of direction * t scaled down by the fraction bits, clamped at 2^34.
   function automatic logic [34:0] clamp_mag(input logic [PHW-1:0] ph, input logic [63:0] pl,
                                             input logic tsat, input logic dnz);
      logic [65:0] sum;
      logic [34:0] m;
      sum = (66'(ph) << (32 - FRAC_BITS)) + 66'(pl >> FRAC_BITS);
      if (tsat) begin
         m = dnz ? Cap : 35'd0;
      end else if (ph >= HiLimit || sum > CapWide) begin
         m = Cap;
      end else begin
         m = sum[34:0];
      end
      return m;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] o, input logic neg,
                                           input logic [34:0] m);
      logic signed [36:0] mv;
      logic signed [36:0] s;
      logic [31:0]        r;
      mv = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
      s  = $signed({{5{o[31]}}, o}) + mv;
      if (s > 37'sd2147483647) begin
         r = 32'h7fffffff;
      end else if (s < -37'sd2147483648) begin
         r = 32'h80000000;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic signed [31:0] box_min_x_ff, box_min_y_ff, box_max_x_ff, box_max_y_ff;
   logic [ThrW-1:0]    thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff <= '0;
         box_min_y_ff <= '0;
         box_max_x_ff <= '0;
         box_max_y_ff <= '0;
         thr_ff       <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BOX_MIN_X: box_min_x_ff <= csr_wdata;
            CSR_BOX_MIN_Y: box_min_y_ff <= csr_wdata;
            CSR_BOX_MAX_X: box_max_x_ff <= csr_wdata;
            CSR_BOX_MAX_Y: box_max_y_ff <= csr_wdata;
            CSR_THRESHOLD: thr_ff       <= csr_wdata[ThrW-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Input stage: slab bounds, parallel tests and divider operands.
   logic signed [31:0] lo_x, hi_x, lo_y, hi_y;
   logic [31:0]        adx, ady;
   logic signed [32:0] n_lx, n_hx, n_ly, n_hy;
   side_type           side0_in;
   logic [QW-1:0]      num0_in [4];

   always_comb begin
      lo_x = (box_min_x_ff < box_max_x_ff) ? box_min_x_ff : box_max_x_ff;
      hi_x = (box_min_x_ff < box_max_x_ff) ? box_max_x_ff : box_min_x_ff;
      lo_y = (box_min_y_ff < box_max_y_ff) ? box_min_y_ff : box_max_y_ff;
      hi_y = (box_min_y_ff < box_max_y_ff) ? box_max_y_ff : box_min_y_ff;
      adx  = mag32(req_direction_x);
      ady  = mag32(req_direction_y);
      n_lx = {lo_x[31], lo_x} - {req_origin_x[31], req_origin_x};
      n_hx = {hi_x[31], hi_x} - {req_origin_x[31], req_origin_x};
      n_ly = {lo_y[31], lo_y} - {req_origin_y[31], req_origin_y};
      n_hy = {hi_y[31], hi_y} - {req_origin_y[31], req_origin_y};
      side0_in.org_x  = req_origin_x;
      side0_in.org_y  = req_origin_y;
      side0_in.dir_x  = req_direction_x;
      side0_in.dir_y  = req_direction_y;
      side0_in.par_x  = !(adx > {16'd0, thr_ff});
      side0_in.par_y  = !(ady > {16'd0, thr_ff});
      side0_in.prej_x = (req_origin_x < lo_x) || (req_origin_x > hi_x);
      side0_in.prej_y = (req_origin_y < lo_y) || (req_origin_y > hi_y);
      side0_in.qneg   = {n_hy[32] ^ req_direction_y[31], n_ly[32] ^ req_direction_y[31],
                         n_hx[32] ^ req_direction_x[31], n_lx[32] ^ req_direction_x[31]};
      num0_in[0] = {mag33(n_lx), {FRAC_BITS{1'b0}}};
      num0_in[1] = {mag33(n_hx), {FRAC_BITS{1'b0}}};
      num0_in[2] = {mag33(n_ly), {FRAC_BITS{1'b0}}};
      num0_in[3] = {mag33(n_hy), {FRAC_BITS{1'b0}}};
   end

   logic          v0_ff;
   side_type      side0_ff;
   logic [QW-1:0] num0_ff [4];
   logic [31:0]   den0_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff   <= side0_in;
         num0_ff    <= num0_in;
         den0_ff[0] <= adx;
         den0_ff[1] <= ady;
      end
   end

   // Slab parameter dividers: low x, high x, low y, high y.
   logic [QW-1:0] quo [4];

   for (genvar k = 0; k < 4; k++) begin : g_div
      rbsi_div #(.QW(QW)) u_div (
         .clock  (clock),
         .en     (en),
         .num_in (num0_ff[k]),
         .den_in (den0_ff[k/2]),
         .quo    (quo[k])
      );
   end

   // Side data and valid bits keep pace with the dividers.
   side_type sd_ff [QW];
   logic     vd_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[s] <= 1'b0;
         end else if (en) begin
            vd_ff[s] <= (s == 0) ? v0_ff : vd_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sd_ff[s] <= (s == 0) ? side0_ff : sd_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   // Signed slab parameters, ordered per axis.
   logic signed [TW-1:0] tq [4];
   logic signed [TW-1:0] tlo1_in [2];
   logic signed [TW-1:0] thi1_in [2];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         tq[k] = sd_ff[QW-1].qneg[k] ? -$signed({2'b00, quo[k]}) : $signed({2'b00, quo[k]});
      end
      for (int a = 0; a < 2; a++) begin
         tlo1_in[a] = (tq[2*a] > tq[2*a+1]) ? tq[2*a+1] : tq[2*a];
         thi1_in[a] = (tq[2*a] > tq[2*a+1]) ? tq[2*a] : tq[2*a+1];
      end
   end

   logic                 v1_ff;
   side_type             side1_ff;
   logic signed [TW-1:0] tlo1_ff [2];
   logic signed [TW-1:0] thi1_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= vd_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= sd_ff[QW-1];
         tlo1_ff  <= tlo1_in;
         thi1_ff  <= thi1_in;
      end
   end

   // Merge the two slabs and pick the parameter of the hit point.
   logic signed [TW-1:0] tin_x, tout_x, tin_y, tout_y, tsel, tabs;
   logic                 rej_x, rej_y;
   logic                 hit2_in, tsat2_in, negx2_in, negy2_in;
   logic [31:0]          dmx2_in, dmy2_in;
   logic [QW-1:0]        tm2_in;

   always_comb begin
      if (!side1_ff.par_x) begin
         tin_x  = tlo1_ff[0];
         tout_x = thi1_ff[0];
         rej_x  = thi1_ff[0] < 0;
      end else begin
         tin_x  = TMin;
         tout_x = TMax;
         rej_x  = side1_ff.prej_x;
      end
      if (!side1_ff.par_y) begin
         tin_y  = (tlo1_ff[1] > tin_x) ? tlo1_ff[1] : tin_x;
         tout_y = (thi1_ff[1] < tout_x) ? thi1_ff[1] : tout_x;
         rej_y  = (tin_y > tout_y) || (tout_y < 0);
      end else begin
         tin_y  = tin_x;
         tout_y = tout_x;
         rej_y  = side1_ff.prej_y;
      end
      hit2_in  = !rej_x && !rej_y;
      tsat2_in = side1_ff.par_x && side1_ff.par_y;
      tsel     = (tin_y > 0) ? tin_y : tout_y;
      tabs     = tsel[TW-1] ? -tsel : tsel;
      tm2_in   = tabs[QW-1:0];
      negx2_in = side1_ff.dir_x[31] != tsel[TW-1];
      negy2_in = side1_ff.dir_y[31] != tsel[TW-1];
      dmx2_in  = mag32(side1_ff.dir_x);
      dmy2_in  = mag32(side1_ff.dir_y);
   end

   logic               v2_ff, hit2_ff, tsat2_ff, negx2_ff, negy2_ff;
   logic signed [31:0] orgx2_ff, orgy2_ff;
   logic [31:0]        dmx2_ff, dmy2_ff;
   logic [QW-1:0]      tm2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit2_ff  <= hit2_in;
         tsat2_ff <= tsat2_in;
         negx2_ff <= negx2_in;
         negy2_ff <= negy2_in;
         orgx2_ff <= side1_ff.org_x;
         orgy2_ff <= side1_ff.org_y;
         dmx2_ff  <= dmx2_in;
         dmy2_ff  <= dmy2_in;
         tm2_ff   <= tm2_in;
      end
   end

   // Partial products of direction and parameter.
   logic               v3_ff, hit3_ff, tsat3_ff, negx3_ff, negy3_ff, dnzx3_ff, dnzy3_ff;
   logic signed [31:0] orgx3_ff, orgy3_ff;
   logic [63:0]        plx3_ff, ply3_ff;
   logic [PHW-1:0]     phx3_ff, phy3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit3_ff  <= hit2_ff;
         tsat3_ff <= tsat2_ff;
         negx3_ff <= negx2_ff;
         negy3_ff <= negy2_ff;
         dnzx3_ff <= dmx2_ff != '0;
         dnzy3_ff <= dmy2_ff != '0;
         orgx3_ff <= orgx2_ff;
         orgy3_ff <= orgy2_ff;
         plx3_ff  <= 64'(dmx2_ff) * 64'(tm2_ff[31:0]);
         ply3_ff  <= 64'(dmy2_ff) * 64'(tm2_ff[31:0]);
         phx3_ff  <= PHW'(dmx2_ff) * PHW'(tm2_ff[QW-1:32]);
         phy3_ff  <= PHW'(dmy2_ff) * PHW'(tm2_ff[QW-1:32]);
      end
   end

   // Clamped product magnitudes.
   logic               v4_ff, hit4_ff, negx4_ff, negy4_ff;
   logic signed [31:0] orgx4_ff, orgy4_ff;
   logic [34:0]        mx4_ff, my4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit4_ff  <= hit3_ff;
         negx4_ff <= negx3_ff;
         negy4_ff <= negy3_ff;
         orgx4_ff <= orgx3_ff;
         orgy4_ff <= orgy3_ff;
         mx4_ff   <= clamp_mag(phx3_ff, plx3_ff, tsat3_ff, dnzx3_ff);
         my4_ff   <= clamp_mag(phy3_ff, ply3_ff, tsat3_ff, dnzy3_ff);
      end
   end

   // Output register with the saturated hit point.
   logic        rsp_hit_ff;
   logic [31:0] rsp_hit_x_ff, rsp_hit_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff   <= hit4_ff;
         rsp_hit_x_ff <= hit4_ff ? sat_add(orgx4_ff, negx4_ff, mx4_ff) : 32'd0;
         rsp_hit_y_ff <= hit4_ff ? sat_add(orgy4_ff, negy4_ff, my4_ff) : 32'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_hit_x = rsp_hit_x_ff;
   assign rsp_hit_y = rsp_hit_y_ff;

endmodule

// ===== hw/rtl/rbsi_checker.sv =====
// Port-level checks for the ray and box intersection block, bound to the top level.
`include "ray_box_slab_intersect_2d_defines.svh"

module rbsi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [31:0] rsp_hit_x,
   input logic [31:0] rsp_hit_y
);
   import rbsi_pkg::*;

   // A stalled result stays put.
   `RBSI_ASSERT_NXT(a_rsp_hold, clock, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit) && $stable(rsp_hit_x) && $stable(rsp_hit_y), reset)

   // A miss carries a zero point.
   `RBSI_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_hit_x == 32'd0 && rsp_hit_y == 32'd0)

   // Requests are held back only by a waiting, stalled result.
   `RBSI_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Reset empties the pipeline and opens the request side.
   `RBSI_ASSERT_NXT_ANY(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind ray_box_slab_intersect_2d rbsi_checker u_rbsi_checker (.*);

// ===== verif/tb_top.sv =====
// Testbench for the 2D ray and box slab intersection block.
`timescale 1ns / 1ps
module tb_top;
   import rbsi_pkg::*;

   localparam int FracBits = 16;
   localparam int Latency = FracBits + 38;
   localparam int WatchdogLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_origin_x = '0, req_origin_y = '0;
   logic signed [31:0] req_direction_x = '0, req_direction_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic signed [31:0] rsp_hit_x, rsp_hit_y;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   typedef struct {
      logic hit;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } hit_point_type;

   hit_point_type pending_hits[$];
   logic signed [31:0] box_lo_x, box_lo_y, box_hi_x, box_hi_y;
   logic [15:0] par_thr;
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   ray_box_slab_intersect_2d #(.FRAC_BITS(FracBits)) u_top (.*);

   always #10 clock = ~clock;

   function automatic logic signed [63:0] scale_mul(logic signed [63:0] d,
                                                    logic signed [63:0] t);
      bit neg;
      logic [63:0] dm, tm, ph, pl, m;
      neg = (d < 0) != (t < 0);
      dm = (d < 0) ? -d : d;
      tm = (t < 0) ? 64'd0 - t : t;
      ph = dm * (tm >> 32);
      pl = dm * (tm & 64'hFFFF_FFFF);
      if (ph >= (64'd1 << (FracBits + 2))) m = 64'd1 << 34;
      else m = (ph << (32 - FracBits)) + (pl >> FracBits);
      if (m > (64'd1 << 34)) m = 64'd1 << 34;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic hit_point_type trace_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                                               logic signed [31:0] dx, logic signed [31:0] dy);
      logic signed [63:0] o[2], d[2], lo[2], hi[2], cmn[2], cmx[2];
      logic signed [63:0] t_in, t_out, ad, t1, t2, tmp, t;
      hit_point_type r;
      bit hit;
      o[0] = ox; o[1] = oy; d[0] = dx; d[1] = dy;
      cmn[0] = box_lo_x; cmn[1] = box_lo_y; cmx[0] = box_hi_x; cmx[1] = box_hi_y;
      t_in = 64'sh8000_0000_0000_0000;
      t_out = 64'sh7FFF_FFFF_FFFF_FFFF;
      hit = 1'b1;
      for (int i = 0; i < 2; i++) begin
         ad = d[i] < 0 ? -d[i] : d[i];
         lo[i] = cmn[i] < cmx[i] ? cmn[i] : cmx[i];
         hi[i] = cmn[i] < cmx[i] ? cmx[i] : cmn[i];
         if (ad > $signed({48'd0, par_thr})) begin
            t1 = ((lo[i] - o[i]) <<< FracBits) / d[i];
            t2 = ((hi[i] - o[i]) <<< FracBits) / d[i];
            if (t1 > t2) begin
               tmp = t1; t1 = t2; t2 = tmp;
            end
            if (t1 > t_in) t_in = t1;
            if (t2 < t_out) t_out = t2;
            if (t_in > t_out || t_out < 0) begin
               hit = 1'b0;
               break;
            end
         end else if (o[i] < lo[i] || o[i] > hi[i]) begin
            hit = 1'b0;
            break;
         end
      end
      r.hit = hit;
      r.x = '0;
      r.y = '0;
      if (hit) begin
         t = t_in > 0 ? t_in : t_out;
         r.x = clamp32(o[0] + scale_mul(d[0], t));
         r.y = clamp32(o[1] + scale_mul(d[1], t));
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Checker of each accepted result against the oldest expectation.
   always @(posedge clock) begin
      hit_point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected result", rsp_hit_x, 0);
         end else begin
            e = pending_hits.pop_front();
            if (rsp_hit !== e.hit) report_mismatch("hit", rsp_hit, e.hit);
            if (rsp_hit_x !== e.x) report_mismatch("hit_x", rsp_hit_x, e.x);
            if (rsp_hit_y !== e.y) report_mismatch("hit_y", rsp_hit_y, e.y);
         end
      end
   end

   // Result-side stall in random bursts.
   always @(posedge clock) begin
      int n;
      if (rsp_quiet) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 19);
         rsp_stall <= 1'b1;
         repeat (n) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // The request stays valid between back-to-back sends and drops only for idle gaps.
   task automatic send_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                           logic signed [31:0] dx, logic signed [31:0] dy);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_origin_x <= ox; req_origin_y <= oy;
      req_direction_x <= dx; req_direction_y <= dy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_hits.push_back(trace_ray(ox, oy, dx, dy));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic write_box(logic signed [31:0] lx, logic signed [31:0] ly,
                            logic signed [31:0] hx, logic signed [31:0] hy, logic [15:0] thr);
      csr_index_type idx[5] = '{CSR_BOX_MIN_X, CSR_BOX_MIN_Y, CSR_BOX_MAX_X,
                                CSR_BOX_MAX_Y, CSR_THRESHOLD};
      logic [31:0] val[5];
      val[0] = lx; val[1] = ly; val[2] = hx; val[3] = hy; val[4] = {16'd0, thr};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      // An index past the register list must be ignored.
      csr_index <= CsrIdxW'(7);
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
      box_lo_x = lx; box_lo_y = ly; box_hi_x = hx; box_hi_y = hy; par_thr = thr;
   endtask

   function automatic logic signed [31:0] rnd_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
         default: return $signed($urandom_range(0, 8)) - 4;
      endcase
   endfunction

   task automatic test_directed;
      write_box(-(2 << 16), -(2 << 16), 2 << 16, 2 << 16, 16'd1);
      send_ray(-(5 << 16), 0, 1 << 16, 0);
      send_ray(0, 0, 1 << 16, 1 << 16);
      send_ray(5 << 16, 5 << 16, 1 << 16, 0);
      send_ray(0, 5 << 16, 1, 0);
      send_ray(0, 0, 0, 0);
      send_ray(0, 0, 1, -1);
      send_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_ray(-(5 << 16), -(5 << 16), -(1 << 16), 1 << 16);
      send_ray(-(5 << 16), 1 << 16, 2, 0);
      send_ray(-1, -1, -1, -1);
      drain();
      // Swapped corners and the largest parallel threshold.
      write_box(2 << 16, 2 << 16, -(2 << 16), -(2 << 16), 16'hFFFF);
      send_ray(-(5 << 16), 0, 1 << 16, 0);
      send_ray(0, 0, 16'hFFFF, 32'h10000);
      send_ray(0, 0, 32'sh8000_0000, 0);
      drain();
      write_box(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd0);
      send_ray(0, 0, 1, 0);
      send_ray(0, 0, -1, 1);
      send_ray(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 3);
      drain();
   endtask

   task automatic test_random(int count, bit idle_free);
      int m;
      quiet = idle_free;
      rsp_quiet = idle_free;
      for (int i = 0; i < count; i++) begin
         if (i % 250 == 0) begin
            drain();
            m = $urandom_range(0, 3);
            write_box(rnd_coord(m == 0 ? 0 : 1), rnd_coord(m == 0 ? 0 : 1),
                      rnd_coord(m == 0 ? 0 : 1), rnd_coord(m == 0 ? 0 : 1),
                      m == 3 ? 16'hFFFF : 16'($urandom_range(0, 8)));
         end
         m = $urandom_range(0, 9);
         send_ray(rnd_coord(m == 0 ? 0 : 1), rnd_coord(m == 0 ? 0 : 1),
                  rnd_coord(m < 2 ? 0 : (m < 4 ? 2 : 1)),
                  rnd_coord(m < 2 ? 0 : (m == 4 ? 2 : 1)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      box_lo_x = 0; box_lo_y = 0; box_hi_x = 0; box_hi_y = 0; par_thr = 16'd1;
      @(posedge clock);
      // Default registers after reset.
      send_ray(0, 0, 0, 0);
      send_ray(-(1 << 16), 0, 1 << 16, 0);
      drain();
      test_directed();
      test_random(1700, 1'b0);
      test_random(300, 1'b1);
      drain();
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
